// ----- src/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_SYNC(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/pidc_pkg.sv -----
// Types, constants and register layout of the PID controller.
package pidc_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   // Mode register bit positions
   localparam int unsigned MODE_TRAP  = 0;
   localparam int unsigned MODE_DMEAS = 1;
   localparam int unsigned MODE_SEP   = 2;
   localparam int unsigned MODE_CLAMP = 3;
   localparam int unsigned MODE_FF    = 4;

   localparam logic signed [31:0] ISUM_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] ISUM_MIN = 32'sh8000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KP        = 3'd0,
      CSR_KI        = 3'd1,
      CSR_KD        = 3'd2,
      CSR_KF        = 3'd3,
      CSR_LIMITS    = 3'd4,
      CSR_INT_LIMIT = 3'd5,
      CSR_INT_TRIG  = 3'd6,
      CSR_MODE      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] kp;
      logic signed [15:0] ki;
      logic signed [15:0] kd;
      logic signed [15:0] kf;
      logic signed [15:0] max_out;
      logic signed [15:0] min_out;
      logic        [14:0] int_limit;
      logic        [14:0] int_trigger;
      logic        [4:0]  mode;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      kp:          16'sd0,
      ki:          16'sd0,
      kd:          16'sd0,
      kf:          16'sd0,
      max_out:     16'sh7fff,
      min_out:     16'sh8000,
      int_limit:   15'h7fff,
      int_trigger: 15'h7fff,
      mode:        5'd0
   };

   // Truncated products handed from the multiply stage to the sum stage
   typedef struct packed {
      logic signed [24:0] p_term;
      logic signed [25:0] i_inc;
      logic signed [25:0] d_term;
      logic signed [24:0] f_raw;
      logic               sep_hit;
   } terms_type;

endpackage

// ----- src/pidc_if.sv -----
// Valid/ready channel interfaces for samples and drive values.
interface pidc_req_if import pidc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [15:0] setpoint;
   logic signed [15:0] measured;

   modport source (output valid, output setpoint, output measured, input ready);
   modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface pidc_rsp_if import pidc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [15:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

// ----- src/pidc_terms.sv -----
// Error differences and the four gain products, truncated to eight fraction bits (Q17.8 and Q18.8).
module pidc_terms import pidc_pkg::*; (
   input  cfg_type            cfg,
   input  logic signed [15:0] setpoint,
   input  logic signed [15:0] measured,
   input  logic signed [15:0] last_setpoint,
   input  logic signed [15:0] last_measured,
   input  logic signed [16:0] last_error,
   output logic signed [16:0] error,
   output terms_type          terms
);

   logic signed [17:0] err_sum;
   logic signed [17:0] err_diff;
   logic signed [17:0] meas_diff;
   logic signed [16:0] sp_diff;
   logic signed [17:0] i_op;
   logic signed [17:0] d_op;
   logic signed [32:0] p_prod;
   logic signed [33:0] i_prod;
   logic signed [33:0] d_prod;
   logic signed [32:0] f_prod;
   logic        [16:0] err_mag;

   assign error     = 17'(setpoint) - 17'(measured);
   assign err_sum   = 18'(error) + 18'(last_error);
   assign err_diff  = 18'(error) - 18'(last_error);
   assign meas_diff = 18'(last_measured) - 18'(measured);
   assign sp_diff   = 17'(setpoint) - 17'(last_setpoint);

   assign i_op = cfg.mode[MODE_TRAP]  ? err_sum   : 18'(error);
   assign d_op = cfg.mode[MODE_DMEAS] ? meas_diff : err_diff;

   assign p_prod = 33'(cfg.kp) * 33'(error);
   assign i_prod = 34'(cfg.ki) * 34'(i_op);
   assign d_prod = 34'(cfg.kd) * 34'(d_op);
   assign f_prod = 33'(cfg.kf) * 33'(sp_diff);

   // magnitude as unsigned so that the most negative error still compares right
   assign err_mag = error[16] ? 17'(-error) : 17'(error);

   // dropping low bits is the floor shift
   assign terms.p_term  = p_prod[32:8];
   assign terms.i_inc   = cfg.mode[MODE_TRAP] ? {i_prod[33], i_prod[33:9]} : i_prod[33:8];
   assign terms.d_term  = d_prod[33:8];
   assign terms.f_raw   = f_prod[32:8];
   assign terms.sep_hit = err_mag > {2'b00, cfg.int_trigger};

endmodule

// ----- src/pid_controller_with_options.sv -----
// PID controller top level: register file, multiply stage and sum stage.
//
//  channel  | dir | transaction content
//  ---------+-----+----------------------------------------------
//  req_bus  | in  | setpoint, measured (signed Q8.8)
//  rsp_bus  | out | drive (signed Q8.8, clamped to output limits)
//  csr_*    | in  | csr_we, csr_index, csr_wdata: one register write
//
// Three register stages: input sample, truncated products, drive value.
// A sample passes the product and drive registers to rsp_bus, one per
// cycle unless the output stalls with the pipeline full. Integral and
// feedforward state close their loop in the sum stage, the difference
// history in the multiply stage. Each stage moves when the one after
// it is empty or draining, so bubbles fill while the output waits.
// Synchronous reset empties all stages and loads the register defaults.
module pid_controller_with_options import pidc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   pidc_req_if.sink               req_bus,
   pidc_rsp_if.source             rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type            cfg_ff, cfg_in;

   logic               s0_v_ff, s0_v_in;
   logic               s1_v_ff, s1_v_in;
   logic               out_v_ff, out_v_in;
   logic               rdy0, rdy1, rdy2;
   logic               acc0, mv01, mv12;

   logic signed [15:0] sp_ff, ms_ff;
   logic signed [15:0] last_sp_ff, last_ms_ff;
   logic signed [16:0] last_err_ff;
   logic signed [16:0] error;
   terms_type          terms;
   terms_type          terms_ff;

   logic signed [31:0] isum_ff, isum_in;
   logic signed [15:0] fterm_ff, fterm_in;
   logic signed [15:0] drive_ff, drive_in;

   // ---------------- register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_KP:        cfg_in.kp          = csr_wdata[15:0];
            CSR_KI:        cfg_in.ki          = csr_wdata[15:0];
            CSR_KD:        cfg_in.kd          = csr_wdata[15:0];
            CSR_KF:        cfg_in.kf          = csr_wdata[15:0];
            CSR_LIMITS: begin
               cfg_in.min_out = csr_wdata[15:0];
               cfg_in.max_out = csr_wdata[31:16];
            end
            CSR_INT_LIMIT: cfg_in.int_limit   = csr_wdata[14:0];
            CSR_INT_TRIG:  cfg_in.int_trigger = csr_wdata[14:0];
            CSR_MODE:      cfg_in.mode        = csr_wdata[4:0];
         endcase
      end
   end

   // ---------------- pipeline flow
   assign rdy2 = !out_v_ff || rsp_bus.ready;
   assign rdy1 = !s1_v_ff || rdy2;
   assign rdy0 = !s0_v_ff || rdy1;
   assign req_bus.ready = rdy0;

   assign acc0 = req_bus.valid && rdy0;
   assign mv01 = s0_v_ff && rdy1;
   assign mv12 = s1_v_ff && rdy2;

   assign s0_v_in  = acc0 || (s0_v_ff && !rdy1);
   assign s1_v_in  = mv01 || (s1_v_ff && !rdy2);
   assign out_v_in = mv12 || (out_v_ff && !rsp_bus.ready);

   // ---------------- multiply stage
   pidc_terms u_terms (
      .cfg           (cfg_ff),
      .setpoint      (sp_ff),
      .measured      (ms_ff),
      .last_setpoint (last_sp_ff),
      .last_measured (last_ms_ff),
      .last_error    (last_err_ff),
      .error         (error),
      .terms         (terms)
   );

   // ---------------- sum stage
   always_comb begin
      logic signed [33:0] acc;
      logic signed [31:0] isum_sat;
      logic signed [31:0] lim;
      logic signed [15:0] half;
      logic signed [16:0] neg_half;
      logic signed [24:0] f_lim;
      logic signed [33:0] total;

      acc = 34'(isum_ff) + 34'(terms_ff.i_inc);
      if (acc > 34'(ISUM_MAX)) begin
         isum_sat = ISUM_MAX;
      end else if (acc < 34'(ISUM_MIN)) begin
         isum_sat = ISUM_MIN;
      end else begin
         isum_sat = acc[31:0];
      end
      if (cfg_ff.mode[MODE_SEP] && terms_ff.sep_hit) begin
         isum_sat = '0;
      end
      lim = $signed({17'd0, cfg_ff.int_limit});
      isum_in = isum_sat;
      if (cfg_ff.mode[MODE_CLAMP]) begin
         if (isum_sat > lim) begin
            isum_in = lim;
         end else if (isum_sat < -lim) begin
            isum_in = -lim;
         end
      end

      // feedforward limited to half the upper output limit
      half     = cfg_ff.max_out >>> 1;
      neg_half = -17'(half);
      f_lim    = terms_ff.f_raw;
      if (terms_ff.f_raw > 25'(half)) begin
         f_lim = 25'(half);
      end else if (terms_ff.f_raw < 25'(neg_half)) begin
         f_lim = 25'(neg_half);
      end
      fterm_in = cfg_ff.mode[MODE_FF] ? f_lim[15:0] : fterm_ff;

      total = 34'(terms_ff.p_term) + 34'(isum_in) + 34'(terms_ff.d_term) + 34'(fterm_in);
      if (total > 34'(cfg_ff.max_out)) begin
         drive_in = cfg_ff.max_out;
      end else if (total < 34'(cfg_ff.min_out)) begin
         drive_in = cfg_ff.min_out;
      end else begin
         drive_in = total[15:0];
      end
   end

   assign rsp_bus.valid = out_v_ff;
   assign rsp_bus.drive = drive_ff;

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= CFG_RESET;
         s0_v_ff     <= 1'b0;
         s1_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
         last_sp_ff  <= '0;
         last_ms_ff  <= '0;
         last_err_ff <= '0;
         isum_ff     <= '0;
         fterm_ff    <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         s0_v_ff  <= s0_v_in;
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
         if (mv01) begin
            last_sp_ff  <= sp_ff;
            last_ms_ff  <= ms_ff;
            last_err_ff <= error;
         end
         if (mv12) begin
            isum_ff  <= isum_in;
            fterm_ff <= fterm_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc0) begin
         sp_ff <= req_bus.setpoint;
         ms_ff <= req_bus.measured;
      end
      if (mv01) begin
         terms_ff <= terms;
      end
      if (mv12) begin
         drive_ff <= drive_in;
      end
   end

endmodule

// ----- src/pidc_checker.sv -----
// Port-level checks of the PID controller, bound to the top level.
`include "assert_macros.svh"

module pidc_checker import pidc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_drive
);

   `ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "output valid after reset")

   `ASSERT_SYNC(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive), "stalled drive value changed")

   // input only backs up when the output is full and stalled
   `ASSERT_SYNC(a_backpressure, !req_ready |-> rsp_valid && !rsp_ready, "input stalled with room in the pipeline")

   // a result that fills an empty output comes from a transaction accepted earlier
   `ASSERT_SYNC(a_latency, $rose(rsp_valid) |-> $past(req_valid && req_ready, 3), "output appeared without matching input")

endmodule

bind pid_controller_with_options pidc_checker u_pidc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_drive (rsp_bus.drive)
);

// ----- test/pid_controller_with_options_tb.sv -----
// Self-checking testbench for the PID controller: directed, random and back-pressure tests.
`timescale 1ns / 100ps

module pid_controller_with_options_tb;
   import pidc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_style_type;
   typedef enum int {PAIR_MIXED, PAIR_WIND_UP, PAIR_WIND_DOWN} pair_style_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   pidc_req_if req_bus ();
   pidc_rsp_if rsp_bus ();

   pid_controller_with_options dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Shadow of the register file and of the controller state
   cfg_type            cfg_shadow = CFG_RESET;
   logic signed [15:0] prev_setpoint = '0;
   logic signed [15:0] prev_measured = '0;
   logic signed [16:0] prev_error    = '0;
   logic signed [31:0] integ_acc     = '0;
   logic signed [15:0] ff_hold       = '0;

   logic signed [15:0] expected_drive[$];

   int           cycle_count    = 0;
   int           mismatch_count = 0;
   int           samples_sent   = 0;
   int           drives_checked = 0;
   int           reg_writes     = 0;
   int           configs_used   = 0;
   int           burst_left     = 0;
   bit           tx_gaps_on     = 1'b1;
   rx_style_type rx_style       = RX_RANDOM;
   int           rx_hold_req    = 0;
   int           rx_hold_cnt    = 0;
   int           rx_tick        = 0;
   logic [15:0]  walk_sp        = '0;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Next drive value for one sample; advances the shadow controller state.
   function automatic logic signed [15:0] predict_drive(input logic signed [15:0] sp,
                                                        input logic signed [15:0] ms);
      longint e, p, inc, isum, mag, lim, dlt, dterm, ff, half, total, mx, mn;
      longint gkp, gki, gkd, gkf;
      gkp = longint'($signed(cfg_shadow.kp));
      gki = longint'($signed(cfg_shadow.ki));
      gkd = longint'($signed(cfg_shadow.kd));
      gkf = longint'($signed(cfg_shadow.kf));
      mx  = longint'($signed(cfg_shadow.max_out));
      mn  = longint'($signed(cfg_shadow.min_out));
      e   = longint'(sp) - longint'(ms);
      p   = (gkp * e) >>> 8;

      if (cfg_shadow.mode[MODE_TRAP])
         inc = (gki * (e + longint'(prev_error))) >>> 9;
      else
         inc = (gki * e) >>> 8;
      isum = longint'(integ_acc) + inc;
      if (isum > longint'(ISUM_MAX)) isum = longint'(ISUM_MAX);
      else if (isum < longint'(ISUM_MIN)) isum = longint'(ISUM_MIN);

      mag = (e < 0) ? -e : e;
      if (cfg_shadow.mode[MODE_SEP] && mag > longint'(cfg_shadow.int_trigger))
         isum = 0;
      if (cfg_shadow.mode[MODE_CLAMP]) begin
         lim = longint'(cfg_shadow.int_limit);
         if (isum > lim) isum = lim;
         else if (isum < -lim) isum = -lim;
      end
      integ_acc = isum[31:0];

      if (cfg_shadow.mode[MODE_DMEAS])
         dlt = longint'(prev_measured) - longint'(ms);
      else
         dlt = e - longint'(prev_error);
      dterm = (gkd * dlt) >>> 8;

      if (cfg_shadow.mode[MODE_FF]) begin
         half = mx >>> 1;
         ff = (gkf * (longint'(sp) - longint'(prev_setpoint))) >>> 8;
         if (ff > half) ff = half;
         else if (ff < -half) ff = -half;
         ff_hold = ff[15:0];
      end

      total = p + isum + dterm + longint'(ff_hold);
      if (total > mx) total = mx;
      else if (total < mn) total = mn;

      prev_setpoint = sp;
      prev_measured = ms;
      prev_error    = e[16:0];
      return total[15:0];
   endfunction

   // Result checker
   always @(posedge clock) begin : check_drive
      logic signed [15:0] want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_drive.size() == 0) begin
            report_mismatch($sformatf("drive %h with no sample outstanding", rsp_bus.drive));
         end else begin
            want = expected_drive.pop_front();
            drives_checked++;
            if (rsp_bus.drive !== want)
               report_mismatch($sformatf("drive %h, expected %h", rsp_bus.drive, want));
         end
      end
   end

   // Receiver: own stall pattern plus an optional long hold-off
   always @(posedge clock) begin
      if (rx_hold_req > 0) begin
         rx_hold_cnt = rx_hold_req;
         rx_hold_req = 0;
      end
      rx_tick++;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rx_hold_cnt > 0) begin
         rsp_bus.ready <= 1'b0;
         rx_hold_cnt--;
      end else begin
         case (rx_style)
            RX_FREE:    rsp_bus.ready <= 1'b1;
            RX_RANDOM:  rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: rsp_bus.ready <= ((rx_tick % 7) < 3);
            default:    rsp_bus.ready <= 1'b1;
         endcase
      end
   end

   // Leaves valid high; the caller lowers it for a gap or at the end.
   task automatic send_sample(input logic [15:0] sp, input logic [15:0] ms);
      req_bus.valid    <= 1'b1;
      req_bus.setpoint <= sp;
      req_bus.measured <= ms;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_drive.push_back(predict_drive(sp, ms));
      samples_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_drive.size() != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] wdata);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      @(posedge clock);
      reg_writes++;
      case (idx)
         CSR_KP:        cfg_shadow.kp = wdata[15:0];
         CSR_KI:        cfg_shadow.ki = wdata[15:0];
         CSR_KD:        cfg_shadow.kd = wdata[15:0];
         CSR_KF:        cfg_shadow.kf = wdata[15:0];
         CSR_LIMITS: begin
            cfg_shadow.max_out = wdata[31:16];
            cfg_shadow.min_out = wdata[15:0];
         end
         CSR_INT_LIMIT: cfg_shadow.int_limit = wdata[14:0];
         CSR_INT_TRIG:  cfg_shadow.int_trigger = wdata[14:0];
         CSR_MODE:      cfg_shadow.mode = wdata[4:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      csr_we <= 1'b0;
      @(posedge clock);
      configs_used++;
   endtask

   // Random bits above the register width; the block must ignore them.
   function automatic logic [31:0] padded(input logic [31:0] val, input int width);
      logic [31:0] m;
      m = (width >= 32) ? 32'hffff_ffff : ((32'h1 << width) - 1);
      return ($urandom & ~m) | (val & m);
   endfunction

   function automatic logic [15:0] pick_extreme();
      case ($urandom_range(0, 4))
         0:       return 16'h7fff;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hffff;
         default: return 16'h0001;
      endcase
   endfunction

   function automatic logic [15:0] rand_gain();
      case ($urandom_range(0, 9))
         0:       return 16'h7fff;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3, 4, 5: return 16'($urandom_range(0, 1024)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [14:0] rand_bound();
      case ($urandom_range(0, 2))
         0:       return 15'h0000;
         1:       return 15'h7fff;
         default: return 15'($urandom);
      endcase
   endfunction

   task automatic next_pair(input pair_style_type style, output logic [15:0] sp,
                            output logic [15:0] ms);
      int pick;
      case (style)
         PAIR_WIND_UP: begin
            sp = 16'h7fff - 16'($urandom_range(0, 15));
            ms = 16'h8000 + 16'($urandom_range(0, 15));
         end
         PAIR_WIND_DOWN: begin
            sp = 16'h8000 + 16'($urandom_range(0, 15));
            ms = 16'h7fff - 16'($urandom_range(0, 15));
         end
         default: begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               // setpoint wanders, feedback tracks it closely
               walk_sp = walk_sp + 16'($urandom_range(0, 64)) - 16'd32;
               if ($urandom_range(0, 31) == 0) walk_sp = 16'($urandom);
               sp = walk_sp;
               ms = walk_sp + 16'($urandom_range(0, 128)) - 16'd64;
            end else if (pick < 8) begin
               sp = 16'($urandom);
               ms = 16'($urandom);
            end else begin
               sp = pick_extreme();
               ms = pick_extreme();
            end
         end
      endcase
   endtask

   task automatic send_stream(input int count, input pair_style_type style);
      logic [15:0] sp, ms;
      int gap;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         next_pair(style, sp, ms);
         send_sample(sp, ms);
         burst_left--;
      end
   endtask

   task automatic load_random_config(input int ph);
      logic [15:0] mx, mn;
      logic [31:0] lim_word;
      logic [4:0]  mode_val;
      case (ph % 5)
         0: lim_word = 32'h7fff_8000;
         1: begin
            mx = 16'($urandom_range(0, 32767));
            mn = 16'h0000 - 16'($urandom_range(0, 32768));
            lim_word = {mx, mn};
         end
         2: begin
            // negative maximum
            mx = 16'h0000 - 16'($urandom_range(1, 32768));
            lim_word = {mx, 16'h8000};
         end
         3: begin
            // minimum above maximum
            mx = 16'($urandom_range(0, 16383));
            mn = mx + 16'($urandom_range(1, 16383));
            lim_word = {mx, mn};
         end
         default: lim_word = ($urandom_range(0, 1) != 0) ? 32'h0 : $urandom;
      endcase
      if (ph == 6)       mode_val = 5'h00;
      else if (ph == 11) mode_val = 5'h1f;
      else               mode_val = 5'($urandom_range(0, 31));
      write_reg(CSR_KP, padded({16'h0, rand_gain()}, 16));
      write_reg(CSR_KI, padded({16'h0, rand_gain()}, 16));
      write_reg(CSR_KD, padded({16'h0, rand_gain()}, 16));
      write_reg(CSR_KF, padded({16'h0, rand_gain()}, 16));
      write_reg(CSR_LIMITS, lim_word);
      write_reg(CSR_INT_LIMIT, padded({17'h0, rand_bound()}, 15));
      write_reg(CSR_INT_TRIG, padded({17'h0, rand_bound()}, 15));
      write_reg(CSR_MODE, padded({27'h0, mode_val}, 5));
      end_writes();
   endtask

   // First sample after reset sees zero history; limits and bounds at reset values.
   task automatic test_first_sample();
      write_reg(CSR_KP, 32'h0000_0100);
      write_reg(CSR_KI, 32'h0000_0040);
      write_reg(CSR_KD, 32'h0000_0080);
      write_reg(CSR_KF, 32'h0000_0100);
      write_reg(CSR_MODE, 32'(1 << MODE_FF) | 32'(1 << MODE_TRAP));
      end_writes();
      send_sample(16'h0400, 16'h0100);
      send_sample(16'h7fff, 16'h8000);
      send_sample(16'h8000, 16'h7fff);
      send_sample(16'h0000, 16'h0000);
      send_sample(16'hffff, 16'h0000);
      wait_drained();
   endtask

   task automatic test_mode_bits();
      write_reg(CSR_KP, 32'h0000_8000);
      write_reg(CSR_KI, 32'h0000_7fff);
      write_reg(CSR_KD, 32'h0000_7fff);
      write_reg(CSR_KF, 32'h0000_8000);
      for (int b = MODE_TRAP; b <= MODE_FF; b++) begin
         write_reg(CSR_MODE, 32'h1 << b);
         end_writes();
         send_sample(16'h0123, 16'hff00);
         send_sample(16'h8000, 16'h0040);
         wait_drained();
      end
   endtask

   task automatic test_output_limits();
      write_reg(CSR_KF, 32'h0000_7fff);
      write_reg(CSR_MODE, 32'(1 << MODE_FF));
      write_reg(CSR_LIMITS, {16'hff00, 16'h8000});
      end_writes();
      send_sample(16'h7fff, 16'h0000);
      send_sample(16'h8000, 16'h0000);
      wait_drained();
      write_reg(CSR_LIMITS, {16'h0100, 16'h0200});
      end_writes();
      send_sample(16'h4000, 16'h0000);
      send_sample(16'h0000, 16'h0010);
      wait_drained();
      write_reg(CSR_LIMITS, 32'h0000_0000);
      end_writes();
      send_sample(16'h7fff, 16'h8000);
      wait_drained();
      write_reg(CSR_LIMITS, 32'h7fff_8000);
      end_writes();
   endtask

   task automatic test_integral_bounds();
      write_reg(CSR_KI, 32'h0000_7fff);
      write_reg(CSR_INT_TRIG, 32'h0000_0000);
      write_reg(CSR_INT_LIMIT, 32'h0000_0000);
      write_reg(CSR_MODE, 32'(1 << MODE_SEP) | 32'(1 << MODE_CLAMP));
      end_writes();
      send_sample(16'h0001, 16'h0000);
      send_sample(16'h0000, 16'h0000);
      wait_drained();
      write_reg(CSR_INT_TRIG, 32'h0000_7fff);
      write_reg(CSR_INT_LIMIT, 32'h0000_0100);
      end_writes();
      send_sample(16'h7fff, 16'h8000);
      send_sample(16'h8000, 16'h7fff);
      wait_drained();
   endtask

   // Drives the integrator into 32-bit saturation and back down past zero.
   task automatic test_integral_windup();
      write_reg(CSR_KP, 32'h0);
      write_reg(CSR_KI, 32'h0000_7fff);
      write_reg(CSR_KD, 32'h0);
      write_reg(CSR_KF, 32'h0);
      write_reg(CSR_LIMITS, 32'h7fff_8000);
      write_reg(CSR_MODE, 32'h0);
      end_writes();
      rx_style = RX_RANDOM;
      send_stream(300, PAIR_WIND_UP);
      send_stream(300, PAIR_WIND_DOWN);
      wait_drained();
   endtask

   task automatic test_random_phases();
      for (int ph = 1; ph <= 11; ph++) begin
         load_random_config(ph);
         rx_style   = rx_style_type'(ph % 3);
         tx_gaps_on = (ph % 4 != 0);
         send_stream(60, PAIR_MIXED);
         wait_drained();
      end
      tx_gaps_on = 1'b1;
   endtask

   // Output stalled long enough that the pipeline fills and req ready drops.
   task automatic test_backpressure();
      load_random_config(1);
      rx_style    = RX_FREE;
      tx_gaps_on  = 1'b0;
      rx_hold_req = 400;
      send_stream(40, PAIR_MIXED);
      wait_drained();
      tx_gaps_on = 1'b1;
   endtask

   task automatic test_drain_pause();
      rx_style = RX_PATTERN;
      send_stream(20, PAIR_MIXED);
      wait_drained();
      rx_style = RX_RANDOM;
      send_stream(20, PAIR_MIXED);
      wait_drained();
   endtask

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.setpoint = '0;
      req_bus.measured = '0;
      rsp_bus.ready    = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_KP;
      csr_wdata        = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_first_sample();
      test_mode_bits();
      test_output_limits();
      test_integral_bounds();
      test_integral_windup();
      test_random_phases();
      test_backpressure();
      test_drain_pause();

      wait_drained();
      repeat (10) @(posedge clock);
      if (expected_drive.size() != 0)
         report_mismatch($sformatf("%0d drive values never arrived", expected_drive.size()));

      $display("Run: %0d samples, %0d drive values checked, %0d register writes, %0d configs",
               samples_sent, drives_checked, reg_writes, configs_used);
      $display("Run: all mode bits, limit corners, integral windup, long output stall, %0d errors",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
